// ----- design/paca_pkg.sv -----
// Shared constants, codes and the job record for the packed array with compaction.
`default_nettype none

package paca_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int CAPACITY_MAX = 65536;
  localparam int ADDR_W_MAX   = $clog2(CAPACITY_MAX);

  localparam int WORD_W   = 32;
  localparam int INDEX_W  = 8;
  localparam int FILL_W   = 9;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int KIND_W   = 2;

  // request operations
  localparam logic [CMD_W-1:0] OP_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] OP_SET    = 2'd1;
  localparam logic [CMD_W-1:0] OP_GET    = 2'd2;
  localparam logic [CMD_W-1:0] OP_REMOVE = 2'd3;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BOUNDS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  // memory work handed from front to back
  localparam logic [KIND_W-1:0] JOB_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] JOB_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] JOB_READ  = 2'd2;
  localparam logic [KIND_W-1:0] JOB_SHIFT = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [ADDR_W_MAX-1:0] addr;   // target entry, or first entry removed
    logic [ADDR_W_MAX-1:0] last;   // last occupied entry, for a shift
    logic [WORD_W-1:0]     value;  // write data, or read_value for JOB_NONE
    logic [STATUS_W-1:0]   status;
    logic [FILL_W-1:0]     fill;
  } paca_job_t;

endpackage

`default_nettype wire

// ----- design/paca_if.sv -----
// Request and response channel interfaces for the packed array.
`default_nettype none

interface paca_req_if;
  import paca_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic [INDEX_W-1:0]        index;
  logic signed [WORD_W-1:0]  value;

  modport source (output valid, cmd, index, value, input ready);
  modport sink   (input valid, cmd, index, value, output ready);
endinterface

interface paca_rsp_if;
  import paca_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [WORD_W-1:0]  read_value;
  logic [STATUS_W-1:0]       status;
  logic [FILL_W-1:0]         fill_count;

  modport source (output valid, read_value, status, fill_count, input ready);
  modport sink   (input valid, read_value, status, fill_count, output ready);
endinterface

`default_nettype wire

// ----- design/paca_front.sv -----
// Front end: accepts requests, checks bounds against its own count, issues jobs.
`default_nettype none

module paca_front #(
  parameter int CAPACITY = paca_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  paca_req_if.sink                         req,
  output logic                             job_valid,
  input  logic                             job_ready,
  output paca_pkg::paca_job_t              job,
  output logic [$clog2(CAPACITY+1)-1:0]    count
);
  import paca_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = CW + ADDR_W_MAX;

  logic [CW-1:0] count_next;
  logic [EW-1:0] cnt_w;
  logic [EW-1:0] idx_w;
  logic [EW-1:0] last_w;
  logic [EW-1:0] next_w;
  logic          in_bounds;
  logic          full;
  logic          accept;

  assign req.ready = job_ready;
  assign job_valid = req.valid;
  assign accept    = req.valid && job_ready;

  always_comb begin
    cnt_w     = {{ADDR_W_MAX{1'b0}}, count};
    idx_w     = {{(EW-INDEX_W){1'b0}}, req.index};
    last_w    = cnt_w - EW'(1);
    in_bounds = idx_w < cnt_w;
    full      = count == CW'(CAPACITY);

    count_next = count;
    job.kind   = JOB_NONE;
    job.addr   = idx_w[ADDR_W_MAX-1:0];
    job.last   = last_w[ADDR_W_MAX-1:0];
    job.value  = '0;
    job.status = ST_OK;

    unique case (req.cmd)
      OP_APPEND: begin
        if (full) begin
          job.status = ST_FULL;
        end else begin
          job.kind   = JOB_WRITE;
          job.addr   = cnt_w[ADDR_W_MAX-1:0];
          job.value  = req.value;
          count_next = count + CW'(1);
        end
      end
      OP_SET: begin
        if (!in_bounds) begin
          job.status = ST_BOUNDS;
        end else begin
          job.kind  = JOB_WRITE;
          job.value = req.value;
        end
      end
      OP_GET: begin
        if (!in_bounds) begin
          job.status = ST_BOUNDS;
          job.value  = '1;
        end else begin
          job.kind = JOB_READ;
        end
      end
      OP_REMOVE: begin
        if (!in_bounds) begin
          job.status = ST_BOUNDS;
        end else begin
          job.kind   = JOB_SHIFT;
          count_next = count - CW'(1);
        end
      end
    endcase

    next_w   = {{ADDR_W_MAX{1'b0}}, count_next};
    job.fill = next_w[FILL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/paca_queue.sv -----
// Two-entry job queue between front and back.
`default_nettype none

module paca_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  paca_pkg::paca_job_t in_job,
  output logic                out_valid,
  input  logic                out_ready,
  output paca_pkg::paca_job_t out_job
);
  import paca_pkg::*;

  localparam int DEPTH = 2;

  paca_job_t  slots [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] used;
  logic       push;
  logic       pop;

  assign in_ready  = used != 2'(DEPTH);
  assign out_valid = used != 2'd0;
  assign out_job   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      used <= used + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_job;
    end
  end

endmodule

`default_nettype wire

// ----- design/paca_back.sv -----
// Back end: runs jobs against the entry memory and holds the result register.
`default_nettype none

module paca_back #(
  parameter int CAPACITY = paca_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  output logic                job_ready,
  input  paca_pkg::paca_job_t job,
  paca_rsp_if.source          rsp
);
  import paca_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;

  logic [WORD_W-1:0] mem [CAPACITY];

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [AW-1:0]     ptr;
  logic [AW-1:0]     ptr_next;
  paca_job_t         cur;
  logic              pop;
  logic [AW-1:0]     jaddr;
  logic [AW-1:0]     jlast;
  logic [AW-1:0]     clast;
  logic              we;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [AW-1:0]     rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              load;
  logic [WORD_W-1:0] load_value;
  paca_job_t         src;

  assign job_ready = (state == S_IDLE) && (!rsp.valid || rsp.ready);
  assign pop       = job_valid && job_ready;
  assign jaddr     = job.addr[AW-1:0];
  assign jlast     = job.last[AW-1:0];
  assign clast     = cur.last[AW-1:0];
  assign src       = (state == S_IDLE) ? job : cur;

  always_comb begin
    state_next = state;
    ptr_next   = ptr;
    we         = 1'b0;
    wr_addr    = jaddr;
    wr_data    = job.value;
    rd_addr    = jaddr;
    load       = 1'b0;
    load_value = '0;

    unique case (state)
      S_IDLE: begin
        if (pop) begin
          unique case (job.kind)
            JOB_NONE: begin
              load       = 1'b1;
              load_value = job.value;
            end
            JOB_WRITE: begin
              we   = 1'b1;
              load = 1'b1;
            end
            JOB_READ: begin
              state_next = S_READ;
            end
            JOB_SHIFT: begin
              if (jaddr == jlast) begin
                load = 1'b1;    // removing the last entry: nothing moves
              end else begin
                rd_addr    = jaddr + AW'(1);
                ptr_next   = jaddr + AW'(1);
                state_next = S_SHIFT;
              end
            end
          endcase
        end
      end
      S_READ: begin
        load       = 1'b1;
        load_value = rd_data;
        state_next = S_IDLE;
      end
      S_SHIFT: begin
        // move the word read last cycle down one place, fetch the next
        we      = 1'b1;
        wr_addr = ptr - AW'(1);
        wr_data = rd_data;
        if (ptr == clast) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end else begin
          rd_addr  = ptr + AW'(1);
          ptr_next = ptr + AW'(1);
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    if (pop) begin
      cur <= job;
    end
    if (load) begin
      rsp.read_value <= load_value;
      rsp.status     <= src.status;
      rsp.fill_count <= src.fill;
    end
  end

endmodule

`default_nettype wire

// ----- design/packed_array_with_compaction_unit.sv -----
// Top level of the packed array with compaction: front end, job queue and back end.
`default_nettype none

// Packed array of signed 32-bit words with a fill count, up to CAPACITY entries.
// Requests arrive on req (cmd, index, value); each one gives exactly one
// transaction on rsp (read_value, status, fill_count), in request order.
// Append adds a word at the end, set overwrites an entry, get reads one, and
// remove deletes one and closes the gap by moving every later entry down one
// place. An index at or beyond the count returns status 1 and changes nothing
// (get then answers -1); an append to a full array returns status 2 and drops
// the word. fill_count is the count after the request, modulo 512.
// The front end checks bounds and keeps the count as requests are accepted, so
// it takes one request a cycle while the two-entry job queue has room. The back
// end owns the single-port-write entry memory: append and set are done in the
// idle state, get goes through the read state for the registered read, and a
// remove moves every later entry down one place, one entry moved per cycle.
// The back end takes its next job only once the result register is empty or
// being emptied, so a stalled result holds the back end while the queue fills.
// Entries come out of reset undefined; no clearing pass.

module packed_array_with_compaction_unit #(
  parameter int CAPACITY = paca_pkg::CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  paca_req_if.sink   req,
  paca_rsp_if.source rsp
);
  import paca_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  // front end to queue
  logic          fq_valid;
  logic          fq_ready;
  paca_job_t     fq_job;
  // queue to back end
  logic          qb_valid;
  logic          qb_ready;
  paca_job_t     qb_job;
  // count as seen by the front end
  logic [CW-1:0] count;

  paca_front #(
    .CAPACITY (CAPACITY)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .job_valid (fq_valid),
    .job_ready (fq_ready),
    .job       (fq_job),
    .count     (count)
  );

  paca_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_job    (fq_job),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_job   (qb_job)
  );

  paca_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .rsp       (rsp)
  );

`ifndef SYNTHESIS
  // the count never runs past the capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("count above capacity");

  // a full-array answer must report a full count
  a_full_fill: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_FULL) |-> (rsp.fill_count == FILL_W'(CAPACITY)))
    else $error("full status with count below capacity");

  // an accepted append with room grows the count by one
  a_append_grow: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.cmd == OP_APPEND && count != CW'(CAPACITY))
    |=> (count == $past(count) + CW'(1)))
    else $error("append did not grow count");
`endif

endmodule

`default_nettype wire
